[hw/rtl/pcap_pkg.sv]
// Package for the PCA projection core: widths, command and register codes,
// the pipeline tag type and the default store size.
// No dependencies; the RTL files refer to it by scoped names, the bench files import it.
package pcap_pkg;

  localparam int DEF_MAX_DIM = 16;

  localparam int VAL_W   = 24;  // data, mean and vector entries
  localparam int BAS_W   = 16;  // Q1.15 basis coefficient
  localparam int IDX_W   = 4;   // row / col / out_index
  localparam int DIM_W   = 5;   // dimension registers
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W    = VAL_W + 1;        // x - mean
  localparam int PROD_W  = OP_W + BAS_W;     // full product
  localparam int FRAC_W  = 15;
  localparam int TERM_W  = PROD_W - FRAC_W;  // product >> 15
  localparam int ACC_W   = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD_MEAN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_BASIS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORWARD    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INVERSE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_DIM = 2'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic signed [ACC_W-1:0] SAT_HI = 32'sd8388607;
  localparam logic signed [ACC_W-1:0] SAT_LO = -32'sd8388608;

  // Control that travels with each multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;     // first term of a result
    logic             lastterm;  // last term of a result
    logic             lastrow;   // final result of the run
    logic [IDX_W-1:0] idx;       // result index
  } pcap_tag_t;

endpackage

[hw/rtl/pca_projection_core.sv]
// Top level of the PCA projection / reconstruction core.
// Instantiates pcap_store, pcap_seq and pcap_mac; uses pcap_pkg.
//
// Usage
//   Input: present in_cmd/in_row/in_col/in_value with start; a transfer
//   happens at a clock edge with start high and busy low.
//   Load mean and load basis items write the stores.
//   Forward and inverse items write the vector buffer; the item that
//   carries the last index of the vector starts a run.
//   A run walks nout results of nin terms each through one shared
//   multiply-accumulate unit, one term per cycle (nin = dim_in_use,
//   nout = reduced_dim for forward, swapped for inverse). busy is set by
//   the trigger transfer and stays high until the final result; results
//   come out in index order. The single multiplier sets the term rate.
//   Output: each result sits on out_* for one cycle with out_valid high;
//   the receiver cannot stall it. out_last marks the final result, and busy
//   falls at the edge that ends that cycle.
//   Configuration: cfg_valid/cfg_ready write dim_in_use (index 0) or
//   reduced_dim (index 1); write only while idle.
//   Reset (synchronous, rst_n low) clears control state and sets both
//   dimensions to 16. Store contents stay undefined until loaded.
module pca_projection_core #(
  parameter int MAX_DIM = pcap_pkg::DEF_MAX_DIM
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcap_pkg::CMD_W-1:0]          in_cmd,
  input  logic [pcap_pkg::IDX_W-1:0]          in_row,
  input  logic [pcap_pkg::IDX_W-1:0]          in_col,
  input  logic signed [pcap_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  output logic signed [pcap_pkg::VAL_W-1:0]   out_value,
  output logic [pcap_pkg::IDX_W-1:0]          out_index,
  output logic                                out_last,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcap_pkg::DIM_W-1:0]          cfg_data
);

  localparam int AW    = $clog2(MAX_DIM);
  localparam int BAW   = $clog2(MAX_DIM * MAX_DIM);
  localparam int XW    = (AW > pcap_pkg::IDX_W) ? AW : pcap_pkg::IDX_W;
  localparam int LIMIT = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam logic [pcap_pkg::DIM_W-1:0] LIMIT_D = pcap_pkg::DIM_W'(LIMIT);

  logic [pcap_pkg::DIM_W-1:0] dim_r, dim_nxt, red_r, red_nxt;
  logic [pcap_pkg::DIM_W-1:0] dim_eff, red_eff, nin, nout, vec_len;
  logic                       busy_r, busy_nxt;
  logic                       fwd_r, fwd_nxt;
  logic                       accept, is_vec, col_in_vec, trigger;
  logic                       load_ok_mean, load_ok_bas;
  logic                       mac_done;
  logic [XW-1:0]              row_ext, col_ext;
  logic [AW-1:0]              row_a, col_a;
  logic [BAW-1:0]             bas_waddr;
  logic [AW-1:0]              vec_raddr, mean_raddr;
  logic [BAW-1:0]             bas_raddr;
  logic [pcap_pkg::VAL_W-1:0] vec_rdata, mean_rdata;
  logic [pcap_pkg::BAS_W-1:0] bas_rdata;
  pcap_pkg::pcap_tag_t        seq_tag;

  // effective dimensions: zero acts as one, clamp to the store size, at most 16
  function automatic logic [pcap_pkg::DIM_W-1:0] eff_dim(
    input logic [pcap_pkg::DIM_W-1:0] d,
    input logic [pcap_pkg::DIM_W-1:0] lim
  );
    logic [pcap_pkg::DIM_W-1:0] e;
    if (d == '0) begin
      e = 5'd1;
    end else if (d > lim) begin
      e = lim;
    end else begin
      e = d;
    end
    return e;
  endfunction

  assign dim_eff = eff_dim(dim_r, LIMIT_D);
  assign red_eff = eff_dim(red_r, LIMIT_D);

  assign accept  = start && !busy_r;
  assign is_vec  = (in_cmd == pcap_pkg::CMD_FORWARD) ||
                   (in_cmd == pcap_pkg::CMD_INVERSE);
  assign vec_len = (in_cmd == pcap_pkg::CMD_FORWARD) ? dim_eff : red_eff;
  assign col_in_vec = ({1'b0, in_col} < vec_len);
  // the element with the last index fires the run
  assign trigger = accept && is_vec && col_in_vec &&
                   ({1'b0, in_col} == vec_len - 5'd1);

  assign load_ok_mean = int'(in_col) < MAX_DIM;
  assign load_ok_bas  = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

  assign row_ext   = XW'(in_row);
  assign col_ext   = XW'(in_col);
  assign row_a     = row_ext[AW-1:0];
  assign col_a     = col_ext[AW-1:0];
  assign bas_waddr = BAW'(int'(row_a) * MAX_DIM + int'(col_a));

  // hold mode for the whole run
  assign fwd_nxt = trigger ? (in_cmd == pcap_pkg::CMD_FORWARD) : fwd_r;
  assign nin     = fwd_r ? dim_eff : red_eff;
  assign nout    = fwd_r ? red_eff : dim_eff;

  always_comb begin
    busy_nxt = busy_r;
    if (trigger) begin
      busy_nxt = 1'b1;
    end else if (mac_done) begin
      busy_nxt = 1'b0;
    end
  end

  // configuration transfer
  assign cfg_ready = 1'b1;
  always_comb begin
    dim_nxt = dim_r;
    red_nxt = red_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcap_pkg::CFG_DIM_IN_USE:  dim_nxt = cfg_data;
        pcap_pkg::CFG_REDUCED_DIM: red_nxt = cfg_data;
        default: begin
          dim_nxt = dim_r;
          red_nxt = red_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fwd_r  <= 1'b1;
      dim_r  <= pcap_pkg::DIM_RESET;
      red_r  <= pcap_pkg::DIM_RESET;
    end else begin
      busy_r <= busy_nxt;
      fwd_r  <= fwd_nxt;
      dim_r  <= dim_nxt;
      red_r  <= red_nxt;
    end
  end

  assign busy = busy_r;

  pcap_store #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW),
    .BAW     (BAW)
  ) u_store (
    .clk        (clk),
    .mean_we    (accept && (in_cmd == pcap_pkg::CMD_LOAD_MEAN) && load_ok_mean),
    .mean_waddr (col_a),
    .mean_wdata (in_value),
    .bas_we     (accept && (in_cmd == pcap_pkg::CMD_LOAD_BASIS) && load_ok_bas),
    .bas_waddr  (bas_waddr),
    .bas_wdata  (in_value[pcap_pkg::BAS_W-1:0]),
    .vec_we     (accept && is_vec && col_in_vec),
    .vec_waddr  (col_a),
    .vec_wdata  (in_value),
    .mean_raddr (mean_raddr),
    .bas_raddr  (bas_raddr),
    .vec_raddr  (vec_raddr),
    .mean_rdata (mean_rdata),
    .bas_rdata  (bas_rdata),
    .vec_rdata  (vec_rdata)
  );

  pcap_seq #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW),
    .BAW     (BAW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (trigger),
    .fwd        (fwd_r),
    .nin        (nin),
    .nout       (nout),
    .vec_raddr  (vec_raddr),
    .mean_raddr (mean_raddr),
    .bas_raddr  (bas_raddr),
    .tag_r      (seq_tag)
  );

  pcap_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .fwd         (fwd_r),
    .tag_in      (seq_tag),
    .vec_rdata   (vec_rdata),
    .mean_rdata  (mean_rdata),
    .bas_rdata   (bas_rdata),
    .res_valid_r (out_valid),
    .res_value_r (out_value),
    .res_index_r (out_index),
    .res_last_r  (out_last),
    .res_sat_r   (out_saturated),
    .done        (mac_done)
  );

  // a result other than the final one only appears inside a run
  a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy_r)
    else $error("non-final result outside a run");

  // no term is in flight once the block reports idle
  a_idle_no_terms: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !seq_tag.valid)
    else $error("sequencer active while idle");

  // a triggering transfer always opens a run
  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    trigger |=> busy_r)
    else $error("run not started after trigger");

  // the final result is never directly followed by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after final result");

endmodule

[hw/rtl/pcap_store.sv]
// Mean, basis and vector memories of the PCA projection core.
// One write port each, one registered read port each. Uses pcap_pkg.
module pcap_store #(
  parameter int MAX_DIM = pcap_pkg::DEF_MAX_DIM,
  parameter int AW      = $clog2(MAX_DIM),
  parameter int BAW     = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                            clk,
  input  logic                            mean_we,
  input  logic [AW-1:0]                   mean_waddr,
  input  logic [pcap_pkg::VAL_W-1:0]      mean_wdata,
  input  logic                            bas_we,
  input  logic [BAW-1:0]                  bas_waddr,
  input  logic [pcap_pkg::BAS_W-1:0]      bas_wdata,
  input  logic                            vec_we,
  input  logic [AW-1:0]                   vec_waddr,
  input  logic [pcap_pkg::VAL_W-1:0]      vec_wdata,
  input  logic [AW-1:0]                   mean_raddr,
  input  logic [BAW-1:0]                  bas_raddr,
  input  logic [AW-1:0]                   vec_raddr,
  output logic [pcap_pkg::VAL_W-1:0]      mean_rdata,
  output logic [pcap_pkg::BAS_W-1:0]      bas_rdata,
  output logic [pcap_pkg::VAL_W-1:0]      vec_rdata
);

  logic [pcap_pkg::VAL_W-1:0] mean_mem [MAX_DIM];
  logic [pcap_pkg::BAS_W-1:0] bas_mem  [MAX_DIM*MAX_DIM];
  logic [pcap_pkg::VAL_W-1:0] vec_mem  [MAX_DIM];

  always_ff @(posedge clk) begin
    if (mean_we) begin
      mean_mem[mean_waddr] <= mean_wdata;
    end
    mean_rdata <= mean_mem[mean_raddr];
  end

  always_ff @(posedge clk) begin
    if (bas_we) begin
      bas_mem[bas_waddr] <= bas_wdata;
    end
    bas_rdata <= bas_mem[bas_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_rdata <= vec_mem[vec_raddr];
  end

endmodule

[hw/rtl/pcap_seq.sv]
// Run sequencer of the PCA projection core: walks result and term counters,
// drives memory read addresses and a tag aligned with the read data.
// Uses pcap_pkg.
module pcap_seq #(
  parameter int MAX_DIM = pcap_pkg::DEF_MAX_DIM,
  parameter int AW      = $clog2(MAX_DIM),
  parameter int BAW     = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic                         fwd,
  input  logic [pcap_pkg::DIM_W-1:0]   nin,
  input  logic [pcap_pkg::DIM_W-1:0]   nout,
  output logic [AW-1:0]                vec_raddr,
  output logic [AW-1:0]                mean_raddr,
  output logic [BAW-1:0]               bas_raddr,
  output pcap_pkg::pcap_tag_t          tag_r
);

  localparam int XW = (AW > pcap_pkg::IDX_W) ? AW : pcap_pkg::IDX_W;

  logic                        active_r, active_nxt;
  logic [pcap_pkg::IDX_W-1:0]  i_r, i_nxt;
  logic [pcap_pkg::IDX_W-1:0]  r_r, r_nxt;
  pcap_pkg::pcap_tag_t         tag_nxt;
  logic                        term_end, row_end;
  logic [XW-1:0]               i_ext, r_ext;
  logic [AW-1:0]               i_a, r_a;

  assign term_end = ({1'b0, i_r} == nin - 5'd1);
  assign row_end  = ({1'b0, r_r} == nout - 5'd1);

  assign i_ext = XW'(i_r);
  assign r_ext = XW'(r_r);
  assign i_a   = i_ext[AW-1:0];
  assign r_a   = r_ext[AW-1:0];

  always_comb begin
    vec_raddr = i_a;
    if (fwd) begin
      mean_raddr = i_a;
      bas_raddr  = BAW'(int'(r_a) * MAX_DIM + int'(i_a));
    end else begin
      mean_raddr = r_a;
      bas_raddr  = BAW'(int'(i_a) * MAX_DIM + int'(r_a));
    end
  end

  always_comb begin
    active_nxt       = active_r;
    i_nxt            = i_r;
    r_nxt            = r_r;
    tag_nxt.valid    = active_r;
    tag_nxt.first    = (i_r == '0);
    tag_nxt.lastterm = term_end;
    tag_nxt.lastrow  = row_end;
    tag_nxt.idx      = r_r;
    if (go) begin
      active_nxt = 1'b1;
      i_nxt      = '0;
      r_nxt      = '0;
    end else if (active_r) begin
      // advance term counter, wrap into the next result
      if (term_end) begin
        i_nxt = '0;
        r_nxt = r_r + 4'd1;
        if (row_end) begin
          active_nxt = 1'b0;
        end
      end else begin
        i_nxt = i_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tag_r    <= '0;
    end else begin
      active_r <= active_nxt;
      tag_r    <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    r_r <= r_nxt;
  end

endmodule

[hw/rtl/pcap_mac.sv]
// Shared multiply-accumulate datapath of the PCA projection core: operand
// forming, one 25x16 multiplier, accumulator and saturating result register.
// Uses pcap_pkg.
module pcap_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fwd,
  input  pcap_pkg::pcap_tag_t               tag_in,
  input  logic [pcap_pkg::VAL_W-1:0]        vec_rdata,
  input  logic [pcap_pkg::VAL_W-1:0]        mean_rdata,
  input  logic [pcap_pkg::BAS_W-1:0]        bas_rdata,
  output logic                              res_valid_r,
  output logic signed [pcap_pkg::VAL_W-1:0] res_value_r,
  output logic [pcap_pkg::IDX_W-1:0]        res_index_r,
  output logic                              res_last_r,
  output logic                              res_sat_r,
  output logic                              done
);

  pcap_pkg::pcap_tag_t tag2_r, tag3_r, tag4_r;

  logic signed [pcap_pkg::OP_W-1:0]   op_r, op_nxt;
  logic signed [pcap_pkg::BAS_W-1:0]  bas2_r;
  logic signed [pcap_pkg::VAL_W-1:0]  madd2_r, madd3_r;
  logic signed [pcap_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [pcap_pkg::TERM_W-1:0] term;
  logic signed [pcap_pkg::ACC_W-1:0]  acc_r, acc_nxt, acc_base;
  logic signed [pcap_pkg::OP_W-1:0]   x_ext, m_ext;

  // operand stage
  assign x_ext  = {vec_rdata[pcap_pkg::VAL_W-1], vec_rdata};
  assign m_ext  = {mean_rdata[pcap_pkg::VAL_W-1], mean_rdata};
  assign op_nxt = fwd ? (x_ext - m_ext) : x_ext;

  // multiply stage
  assign prod_nxt = op_r * bas2_r;

  // accumulate stage: floor shift, then add; the mean seeds an inverse row
  assign term     = prod_r[pcap_pkg::PROD_W-1:pcap_pkg::FRAC_W];
  assign acc_base = tag3_r.first ? pcap_pkg::ACC_W'(madd3_r) : acc_r;
  assign acc_nxt  = acc_base + pcap_pkg::ACC_W'(term);

  assign done = res_valid_r && res_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r      <= '0;
      tag3_r      <= '0;
      tag4_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      tag2_r      <= tag_in;
      tag3_r      <= tag2_r;
      tag4_r      <= tag3_r.valid ? tag3_r : '0;
      res_valid_r <= tag4_r.valid && tag4_r.lastterm;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    bas2_r  <= bas_rdata;
    madd2_r <= fwd ? '0 : mean_rdata;
    prod_r  <= prod_nxt;
    madd3_r <= madd2_r;
    if (tag3_r.valid) begin
      acc_r <= acc_nxt;
    end
    // clip the finished sum into the result register
    res_index_r <= tag4_r.idx;
    res_last_r  <= tag4_r.lastrow;
    if (acc_r > pcap_pkg::SAT_HI) begin
      res_value_r <= pcap_pkg::SAT_HI[pcap_pkg::VAL_W-1:0];
      res_sat_r   <= 1'b1;
    end else if (acc_r < pcap_pkg::SAT_LO) begin
      res_value_r <= pcap_pkg::SAT_LO[pcap_pkg::VAL_W-1:0];
      res_sat_r   <= 1'b1;
    end else begin
      res_value_r <= acc_r[pcap_pkg::VAL_W-1:0];
      res_sat_r   <= 1'b0;
    end
  end

endmodule

[sim/pcap_check_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the PCA projection core bench: a bit-exact predictor of
// projection and reconstruction runs plus the queue of results still awaited.
// Depends on pcap_pkg for widths and for the command and register codes.
package pcap_check_pkg;
  import pcap_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_DIM;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    last;
    logic                    saturated;
  } proj_result_t;

  class projection_scoreboard;
    logic signed [VAL_W-1:0] mean_mem [STORE_DEPTH];
    logic signed [BAS_W-1:0] basis_mem [STORE_DEPTH][STORE_DEPTH];
    logic signed [VAL_W-1:0] vec_mem [STORE_DEPTH];
    logic [DIM_W-1:0]        dim_reg;
    logic [DIM_W-1:0]        red_reg;
    proj_result_t            awaited_q [$];
    int                      errors;

    function new();
      dim_reg = DIM_RESET;
      red_reg = DIM_RESET;
      errors  = 0;
      foreach (mean_mem[i]) begin
        mean_mem[i] = '0;
        vec_mem[i]  = '0;
      end
      foreach (basis_mem[r, c]) basis_mem[r][c] = '0;
    endfunction

    // Zero acts as one, anything past the store size as the store size
    function int unsigned eff_len(logic [DIM_W-1:0] r);
      if (r == 0) return 1;
      if (r > STORE_DEPTH) return STORE_DEPTH;
      return r;
    endfunction

    function int unsigned vector_len(logic [CMD_W-1:0] cmd);
      return (cmd == CMD_INVERSE) ? eff_len(red_reg) : eff_len(dim_reg);
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        CFG_DIM_IN_USE:  dim_reg = data;
        CFG_REDUCED_DIM: red_reg = data;
        default: ;
      endcase
    endfunction

    function void queue_result(longint sum, int unsigned idx, bit last);
      proj_result_t res;
      res.saturated = 1'b0;
      if (sum > longint'(SAT_HI)) begin
        sum = SAT_HI;
        res.saturated = 1'b1;
      end
      if (sum < longint'(SAT_LO)) begin
        sum = SAT_LO;
        res.saturated = 1'b1;
      end
      res.value = sum[VAL_W-1:0];
      res.index = idx[IDX_W-1:0];
      res.last  = last;
      awaited_q.push_back(res);
    endfunction

    function void run_forward(int unsigned dim, int unsigned red);
      longint sum;
      longint diff;
      for (int unsigned r = 0; r < red; r++) begin
        sum = 0;
        for (int unsigned i = 0; i < dim; i++) begin
          diff = longint'(vec_mem[i]) - longint'(mean_mem[i]);
          sum += (longint'(basis_mem[r][i]) * diff) >>> FRAC_W;
        end
        queue_result(sum, r, r == red - 1);
      end
    endfunction

    function void run_inverse(int unsigned dim, int unsigned red);
      longint sum;
      for (int unsigned c = 0; c < dim; c++) begin
        sum = 0;
        for (int unsigned i = 0; i < red; i++)
          sum += (longint'(basis_mem[i][c]) * longint'(vec_mem[i])) >>> FRAC_W;
        sum += longint'(mean_mem[c]);
        queue_result(sum, c, c == dim - 1);
      end
    endfunction

    // Apply one accepted input transfer; return 0 when the block ignores it
    function bit note_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] value);
      int unsigned dim;
      int unsigned red;
      dim = eff_len(dim_reg);
      red = eff_len(red_reg);
      case (cmd)
        CMD_LOAD_MEAN: begin
          mean_mem[col] = value;
          return 1'b1;
        end
        CMD_LOAD_BASIS: begin
          basis_mem[row][col] = value[BAS_W-1:0];
          return 1'b1;
        end
        CMD_FORWARD: begin
          if (col >= dim) return 1'b0;
          vec_mem[col] = value;
          if (col == dim - 1) run_forward(dim, red);
          return 1'b1;
        end
        default: begin
          if (col >= red) return 1'b0;
          vec_mem[col] = value;
          if (col == red - 1) run_inverse(dim, red);
          return 1'b1;
        end
      endcase
    endfunction

    function void check_result(logic signed [VAL_W-1:0] value, logic [IDX_W-1:0] index,
                               logic last, logic saturated);
      proj_result_t want;
      if (awaited_q.size() == 0) begin
        $error("result with nothing awaited: out_value %0d out_index %0d", value, index);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      if (value !== want.value) begin
        $error("out_value mismatch: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (index !== want.index) begin
        $error("out_index mismatch: expected %0d, actual %0d", want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (saturated !== want.saturated) begin
        $error("out_saturated mismatch: expected %0b, actual %0b", want.saturated, saturated);
        errors++;
      end
    endfunction
  endclass

endpackage

[sim/tb_pca_projection_core.sv]
`timescale 1ns / 100ps
// Self-checking bench for pca_projection_core: random and directed command
// traffic with every result checked against pcap_check_pkg's scoreboard.
// Depends on pcap_pkg, pcap_check_pkg and the core RTL.
module tb_pca_projection_core;
  import pcap_pkg::*;
  import pcap_check_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 140;
  localparam int QUIET_TAIL    = 40;                            // last items run without gaps
  localparam int SETTLE_CYCLES = 8;                             // cover one-cycle load items
  localparam int TAIL_CYCLES   = DEF_MAX_DIM * DEF_MAX_DIM + 8; // one full run and margin
  localparam int LIMIT_CYCLES  = 1_000_000;

  // Register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    start         = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        in_cmd        = CMD_LOAD_MEAN;
  logic [IDX_W-1:0]        in_row        = '0;
  logic [IDX_W-1:0]        in_col        = '0;
  logic signed [VAL_W-1:0] in_value      = '0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic [IDX_W-1:0]        out_index;
  logic                    out_last;
  logic                    out_saturated;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index     = CFG_DIM_IN_USE;
  logic [DIM_W-1:0]        cfg_data      = '0;

  projection_scoreboard sb;
  int  cycle_count   = 0;
  int  applied_items = 0;   // transfers that the block acts on
  bit  gaps_on       = 1'b1;

  pca_projection_core #(
    .MAX_DIM(DEF_MAX_DIM)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_index    (out_index),
    .out_last     (out_last),
    .out_saturated(out_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Results cannot be held off: take each one at the edge that closes its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_value, out_index, out_last, out_saturated);
  end

  // Mix of full-range, mid-range, tiny and extreme values so that some runs
  // saturate and others stay in range
  function automatic logic signed [VAL_W-1:0] rand_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = VAL_W'($urandom);
      2:    v = VAL_W'($urandom_range(0, 2047) - 1024);
      3:    v = VAL_W'($urandom_range(0, 1 << 18) - (1 << 17));
      4: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = VAL_W'($urandom_range(0, 255) - 128);
    endcase
    return v;
  endfunction

  // Mostly small sizes; zero and oversize values check the clamping
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'($urandom_range(DEF_MAX_DIM + 1, (1 << DIM_W) - 1));
      2:       return DIM_W'(DEF_MAX_DIM);
      3:       return 5'd1;
      4, 5:    return DIM_W'($urandom_range(9, DEF_MAX_DIM));
      default: return DIM_W'($urandom_range(2, 8));
    endcase
  endfunction

  // Present one item and hold it until the transfer; start stays high so a
  // following item can go out back to back
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] value);
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_row   <= row;
    in_col   <= col;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    if (sb.note_item(cmd, row, col, value)) applied_items++;
  endtask

  // Now and then, while gaps are on, drop start for a gap of random length
  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off until every awaited result is in and the core is idle, then
  // leave room for a trailing load item to retire
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register transfer; cfg_valid is left high for the caller to drop
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Write both dimensions while idle; the spare writes come last so a
  // decoder that aliases them would clobber the real settings
  task automatic reconfigure(input logic [DIM_W-1:0] dim, input logic [DIM_W-1:0] red,
                             input bit spare);
    settle();
    cfg_put(CFG_DIM_IN_USE, dim);
    cfg_put(CFG_REDUCED_DIM, red);
    if (spare) begin
      cfg_put(CFG_SPARE_A, DIM_W'($urandom));
      cfg_put(CFG_SPARE_B, DIM_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Fill every store entry once so no run ever reads an unwritten location;
  // vector element 15 is left to the first full-size trigger
  task automatic prime_stores();
    for (int c = 0; c < DEF_MAX_DIM; c++) begin
      send_item(CMD_LOAD_MEAN, IDX_W'($urandom), IDX_W'(c), rand_value());
      idle_gap();
    end
    for (int r = 0; r < DEF_MAX_DIM; r++) begin
      for (int c = 0; c < DEF_MAX_DIM; c++) begin
        send_item(CMD_LOAD_BASIS, IDX_W'(r), IDX_W'(c), rand_value());
        idle_gap();
      end
    end
    for (int c = 0; c < DEF_MAX_DIM - 1; c++) begin
      send_item(CMD_FORWARD, IDX_W'($urandom), IDX_W'(c), rand_value());
      idle_gap();
    end
  endtask

  task automatic directed_checks();
    // Field extremes at reset size: full 16x16 forward and inverse runs
    send_item(CMD_LOAD_MEAN, 0, 0, VAL_MIN);
    send_item(CMD_LOAD_MEAN, 15, 15, VAL_MAX);
    send_item(CMD_LOAD_BASIS, 0, 0, 24'hFF8000);    // -1.0, upper bits set
    send_item(CMD_LOAD_BASIS, 15, 15, 24'h007FFF);  // just under +1.0
    send_item(CMD_FORWARD, 15, 15, VAL_MAX);
    idle_gap();
    send_item(CMD_INVERSE, 0, 15, VAL_MIN);

    // Smallest size, ignored spare indexes, out-of-range element indexes
    reconfigure(1, 1, 1'b1);
    send_item(CMD_FORWARD, 3, 0, '0);
    send_item(CMD_INVERSE, 12, 0, '1);
    send_item(CMD_FORWARD, 0, 5, VAL_MAX);
    send_item(CMD_INVERSE, 0, 1, VAL_MIN);

    // Zero clamps up to one, oversize clamps down to the store size
    reconfigure('0, '1, 1'b0);
    send_item(CMD_FORWARD, 0, 0, VAL_MAX);
    send_item(CMD_INVERSE, 0, 15, VAL_MIN);
    reconfigure('1, '0, 1'b0);
    send_item(CMD_INVERSE, 0, 0, 24'sd4096);
    send_item(CMD_FORWARD, 0, 15, -24'sd4096);

    // Small in-range sums, floor rounding of a negative product, and a
    // trigger that comes before the other elements of its vector
    reconfigure(3, 2, 1'b0);
    send_item(CMD_LOAD_MEAN, 0, 0, 24'sd100);
    send_item(CMD_LOAD_MEAN, 0, 1, -24'sd100);
    send_item(CMD_LOAD_MEAN, 0, 2, '0);
    send_item(CMD_LOAD_BASIS, 0, 0, 24'sd16384);
    send_item(CMD_LOAD_BASIS, 1, 1, -24'sd1);
    send_item(CMD_FORWARD, 0, 2, 24'sd7);
    send_item(CMD_FORWARD, 0, 0, 24'sd101);
    send_item(CMD_FORWARD, 0, 1, -24'sd99);
    send_item(CMD_FORWARD, 0, 2, '0);
    send_item(CMD_INVERSE, 0, 1, 24'sd3);
  endtask

  // A few random loads, then one vector with its earlier elements in random
  // order (some skipped) and the last index as trigger
  task automatic vector_sequence();
    logic [CMD_W-1:0] mode;
    int n;
    int j;
    int tmp;
    int order [DEF_MAX_DIM];
    mode = $urandom_range(0, 1) ? CMD_FORWARD : CMD_INVERSE;
    n = sb.vector_len(mode);
    repeat ($urandom_range(0, 3)) begin
      send_item($urandom_range(0, 1) ? CMD_LOAD_BASIS : CMD_LOAD_MEAN,
                IDX_W'($urandom), IDX_W'($urandom), rand_value());
      idle_gap();
    end
    for (int k = 0; k < n - 1; k++) order[k] = k;
    for (int k = n - 2; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < n - 1; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        send_item(mode, IDX_W'($urandom), IDX_W'(order[k]), rand_value());
        idle_gap();
      end
    end
    // Stray index past the vector length: must be dropped
    if (n < DEF_MAX_DIM && $urandom_range(0, 5) == 0) begin
      send_item(mode, IDX_W'($urandom), IDX_W'($urandom_range(n, DEF_MAX_DIM - 1)),
                rand_value());
      idle_gap();
    end
    send_item(mode, IDX_W'($urandom), IDX_W'(n - 1), rand_value());
    idle_gap();
  endtask

  // Unstructured items: any command, any index, any value
  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      send_item(CMD_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), rand_value());
      idle_gap();
    end
  endtask

  task automatic random_traffic();
    int seq;
    seq = 0;
    applied_items = 0;
    while (applied_items < RANDOM_ITEMS) begin
      if (seq % 6 == 0) reconfigure(pick_dim(), pick_dim(), $urandom_range(0, 7) == 0);
      // Gap-free stretches, and no gaps at all near the end
      gaps_on = (applied_items < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) noise_burst();
      else vector_sequence();
      if ($urandom_range(0, 11) == 0) settle();
      seq++;
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    prime_stores();
    directed_checks();
    random_traffic();
    // Drain, then watch a while longer for stray results
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pcap_pkg.sv
hw/rtl/pcap_store.sv
hw/rtl/pcap_seq.sv
hw/rtl/pcap_mac.sv
hw/rtl/pca_projection_core.sv
sim/pcap_check_pkg.sv
sim/tb_pca_projection_core.sv
